// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, muted while rst is high
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, muted while rst is high
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bes_pkg.sv
// shared types and constants for the bounded element set
`timescale 1ns / 1ps

package bes_pkg;

  // store size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // request codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } bes_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic res_busy;
  } bes_sts_t;

endpackage

// File: rtl/bes_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

// request channel: one operation and its value per item
interface bes_req_if;
  logic                               valid;
  logic                               ready;
  logic [bes_pkg::OP_W-1:0]           op;
  logic signed [bes_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// result channel: outcome, count and empty flag per item
interface bes_res_if;
  logic                         valid;
  logic                         ready;
  logic [bes_pkg::STATUS_W-1:0] status;
  logic [bes_pkg::COUNT_W-1:0]  count;
  logic                         empty_res;

  modport source (output valid, output status, output count, output empty_res, input ready);
  modport sink   (input valid, input status, input count, input empty_res, output ready);
endinterface

// File: rtl/bes_ctrl.sv
// controller: sequences compare and execute for each item
`timescale 1ns / 1ps

module bes_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bes_pkg::bes_sts_t  sts,
  output bes_pkg::bes_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // handshake and commands
  always_comb begin
    req_ready   = (state == ST_IDLE);
    cmd.capture = req_valid && (state == ST_IDLE);
    cmd.exec    = (state == ST_EXEC) && !sts.res_busy;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.exec) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/bes_dp.sv
// datapath: register cells, parallel compare, shift-down and result register
`timescale 1ns / 1ps

module bes_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  bes_pkg::bes_cmd_t                  cmd,
  output bes_pkg::bes_sts_t                  sts,
  input  logic [bes_pkg::OP_W-1:0]           req_op,
  input  logic signed [bes_pkg::VALUE_W-1:0] req_value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [bes_pkg::STATUS_W-1:0]       res_status,
  output logic [bes_pkg::COUNT_W-1:0]        res_count,
  output logic                               res_empty
);

  logic [bes_pkg::VALUE_W-1:0]  cells [bes_pkg::CAPACITY];
  logic [bes_pkg::CNT_W-1:0]    used;
  logic [bes_pkg::CNT_W-1:0]    used_next;
  logic [bes_pkg::OP_W-1:0]     op_q;
  logic [bes_pkg::VALUE_W-1:0]  value_q;
  logic [bes_pkg::CAPACITY-1:0] match;
  logic [bes_pkg::CAPACITY-1:0] match_q;
  logic [bes_pkg::CAPACITY-1:0] shift;
  logic                         found;
  logic                         full;
  logic                         do_add;
  logic                         do_remove;
  logic [bes_pkg::STATUS_W-1:0] status_next;

  // per-cell compare against the incoming value, masked to held entries,
  // and the shift mask: cells at or above the matching one move down
  for (genvar i = 0; i < bes_pkg::CAPACITY; i++) begin : g_cmp
    assign match[i] = (cells[i] == req_value) && (used > bes_pkg::CNT_W'(i));
    assign shift[i] = |match_q[i:0];
  end

  // outcome of the captured request
  always_comb begin
    found       = |match_q;
    full        = (used == bes_pkg::CNT_W'(bes_pkg::CAPACITY));
    do_add      = 1'b0;
    do_remove   = 1'b0;
    status_next = bes_pkg::ST_NONE;
    case (op_q)
      bes_pkg::OP_ADD: begin
        if (found) begin
          status_next = bes_pkg::ST_NONE;
        end else if (full) begin
          status_next = bes_pkg::ST_FULL;
        end else begin
          status_next = bes_pkg::ST_OK;
          do_add      = 1'b1;
        end
      end
      bes_pkg::OP_REMOVE: begin
        if (found) begin
          status_next = bes_pkg::ST_OK;
          do_remove   = 1'b1;
        end
      end
      bes_pkg::OP_SEARCH: begin
        status_next = found ? bes_pkg::ST_OK : bes_pkg::ST_NONE;
      end
      default: status_next = bes_pkg::ST_NONE;
    endcase

    used_next = used;
    if (do_add)    used_next = used + 1'b1;
    if (do_remove) used_next = used - 1'b1;
  end

  // cell update: shift down on remove, append at the end on add
  for (genvar i = 0; i < bes_pkg::CAPACITY; i++) begin : g_cell
    if (i < bes_pkg::CAPACITY - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.exec && do_remove && shift[i]) begin
          cells[i] <= cells[i + 1];
        end else if (cmd.exec && do_add && (used[bes_pkg::IDX_W-1:0] == bes_pkg::IDX_W'(i))) begin
          cells[i] <= value_q;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.exec && do_add && (used[bes_pkg::IDX_W-1:0] == bes_pkg::IDX_W'(i))) begin
          cells[i] <= value_q;
        end
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= req_op;
      value_q <= req_value;
      match_q <= match;
    end
  end

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      used <= used_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_count  <= bes_pkg::COUNT_W'(used_next);
      res_empty  <= (used_next == '0);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.exec) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign sts.res_busy = res_valid && !res_ready;

endmodule

// File: rtl/bounded_element_set.sv
// top level: set of distinct values in register cells with parallel compare
// flow: an accepted request item is captured with its compare result, then the result is
//   registered in the execute state; one item is handled at a time (compare, then execute);
//   execute waits while an earlier result is still held on the result channel
// reset: rst (synchronous) empties the set and drops result valid;
//   cell contents are not cleared, entries at or above the count are ignored
`timescale 1ns / 1ps

module bounded_element_set (
  input logic          clk,
  input logic          rst,
  bes_req_if.sink      req,
  bes_res_if.source    res
);

  bes_pkg::bes_cmd_t cmd;
  bes_pkg::bes_sts_t sts;

  // sequencing
  bes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // cells, compare and result register
  bes_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_op     (req.op),
    .req_value  (req.value),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_count  (res.count),
    .res_empty  (res.empty_res)
  );

endmodule

// File: rtl/bes_checker.sv
// port-level checks for the bounded element set, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bes_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [bes_pkg::STATUS_W-1:0] res_status,
  input logic [bes_pkg::COUNT_W-1:0]  res_count,
  input logic                         res_empty
);

  // empty flag agrees with the count
  `ASSERT_IMPL(a_empty_count, res_valid, res_empty == (res_count == '0), "empty flag and count disagree")

  // count never exceeds the store
  `ASSERT_IMPL(a_count_cap, res_valid, res_count <= bes_pkg::COUNT_W'(bes_pkg::CAPACITY), "count above capacity")

  // full is only reported at capacity, with the count unchanged
  `ASSERT_IMPL(a_full_cap, res_valid && (res_status == bes_pkg::ST_FULL), res_count == bes_pkg::COUNT_W'(bes_pkg::CAPACITY), "full reported below capacity")

  // one item in flight: no request taken in the cycle after one is accepted
  `ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready, "request taken while busy")

  // a stalled result stays offered
  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

endmodule

bind bounded_element_set bes_checker u_bes_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_count  (res.count),
  .res_empty  (res.empty_res)
);
